// ===== hdl/msps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types, constants and coil pattern lookup of the stepper phase
// sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

   localparam int unsigned MaxAxes    = 4;
   localparam int unsigned CsrIdxW    = 3;
   localparam int unsigned CsrDataW   = 4;
   localparam int unsigned StepW      = 8;
   localparam int unsigned PhaseW     = 3;
   localparam int unsigned CoilW      = 4;
   localparam int unsigned EnableW    = 2;

   typedef enum logic {
      OP_STEP   = 1'b0,
      OP_ENABLE = 1'b1
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_AXIS_ACTIVE = 3'd0,
      CSR_FOUR_PIN    = 3'd1,
      CSR_HALF_STEP   = 3'd2,
      CSR_USE_EN1     = 3'd3,
      CSR_USE_EN2     = 3'd4
   } csr_index_type;

   // per-axis view of the configuration masks
   typedef struct packed {
      logic active;
      logic four_pin;
      logic half_step;
      logic use_en1;
      logic use_en2;
   } axis_cfg_type;

   // command fields shared by all lanes
   typedef struct packed {
      op_type op;
      logic   level_on;
      logic   force_req;
   } lane_cmd_type;

   // what one lane reports after a transaction
   typedef struct packed {
      logic [CoilW-1:0]   coil;
      logic [EnableW-1:0] enable;
      logic               powered;
   } lane_out_type;

   localparam logic [CoilW-1:0] HALF4_TABLE [8] = '{
      4'd10, 4'd8, 4'd9, 4'd1, 4'd5, 4'd4, 4'd6, 4'd2
   };
   localparam logic [CoilW-1:0] FULL4_TABLE [4] = '{4'd10, 4'd9, 4'd5, 4'd6};
   localparam logic [CoilW-1:0] FULL2_TABLE [4] = '{4'd3, 4'd2, 4'd0, 4'd1};

   function automatic logic [CoilW-1:0] coil_pattern(
      input logic [PhaseW-1:0] phase,
      input logic              four_pin,
      input logic              half_step
   );
      logic [CoilW-1:0] pattern;
      if (four_pin) begin
         if (half_step) begin
            pattern = HALF4_TABLE[phase];
         end else begin
            pattern = FULL4_TABLE[phase[1:0]];
         end
      end else begin
         pattern = FULL2_TABLE[phase[1:0]];
      end
      return pattern;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/msps_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_req_if
// Command channel: valid/ready handshake with step and enable fields.
// ----------------------------------------------------------------------------
interface msps_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] steps_axis0;
   logic [7:0] steps_axis1;
   logic [7:0] steps_axis2;
   logic [7:0] steps_axis3;
   logic [3:0] direction_up;
   logic [1:0] target_axis;
   logic       level_on;
   logic       force_req;

   modport source (
      output valid, op, steps_axis0, steps_axis1, steps_axis2, steps_axis3,
             direction_up, target_axis, level_on, force_req,
      input  ready
   );
   modport sink (
      input  valid, op, steps_axis0, steps_axis1, steps_axis2, steps_axis3,
             direction_up, target_axis, level_on, force_req,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/msps_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_rsp_if
// Result channel: valid/ready handshake with pin levels and status.
// ----------------------------------------------------------------------------
interface msps_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] coil_pins;
   logic [7:0]  enable_pins;
   logic [3:0]  enabled_status;

   modport source (
      output valid, coil_pins, enable_pins, enabled_status,
      input  ready
   );
   modport sink (
      input  valid, coil_pins, enable_pins, enabled_status,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/msps_csr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_csr_if
// Configuration write channel: valid/ready handshake, register index, data.
// ----------------------------------------------------------------------------
interface msps_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [3:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/msps_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_lane
// One axis: phase index, coil and enable levels, and the per-transaction
// update for step and set enable commands.
// ----------------------------------------------------------------------------
module msps_lane
   import msps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire axis_cfg_type       cfg,
   input  wire lane_cmd_type       cmd,
   input  wire logic [StepW-1:0]   steps,
   input  wire logic               dir_up,
   input  wire logic               target_hit,
   output lane_out_type            result
);

   logic [PhaseW-1:0]  phase_ff,  phase_in;
   logic [CoilW-1:0]   coil_ff,   coil_in;
   logic [EnableW-1:0] enable_ff, enable_in;

   always_comb begin
      phase_in  = phase_ff;
      coil_in   = coil_ff;
      enable_in = enable_ff;
      if (cmd.op == OP_STEP) begin
         if (steps != '0) begin
            // index wraps modulo 8, so only the low count bits matter
            phase_in = dir_up ? phase_ff + steps[PhaseW-1:0]
                              : phase_ff - steps[PhaseW-1:0];
            if (cfg.active) begin
               coil_in = coil_pattern(phase_in, cfg.four_pin, cfg.half_step);
            end
         end
      end else if (target_hit && cfg.active) begin
         if (cfg.use_en1) begin
            enable_in = {enable_ff[1], cmd.level_on};
            if (cfg.use_en2) begin
               enable_in = {cmd.level_on, cmd.level_on};
            end
         end else if (cfg.four_pin) begin
            if (!cmd.level_on) begin
               coil_in = '0;
            end else if (cmd.force_req) begin
               coil_in = coil_pattern(phase_ff, cfg.four_pin, cfg.half_step);
            end
         end
      end
   end

   always_comb begin
      result.coil   = coil_in;
      result.enable = enable_in;
      if (!cfg.active) begin
         result.powered = 1'b0;
      end else if (cfg.use_en1) begin
         result.powered = enable_in[0] && (!cfg.use_en2 || enable_in[1]);
      end else begin
         result.powered = !cfg.four_pin || (coil_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         coil_ff   <= '0;
         enable_ff <= '0;
      end else if (load) begin
         phase_ff  <= phase_in;
         coil_ff   <= coil_in;
         enable_ff <= enable_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/msps_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_merge
// Pack the lane results into the pin words and hold them in the output
// register until the result transaction completes.
// ----------------------------------------------------------------------------
module msps_merge
   import msps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire lane_out_type  lanes [MaxAxes],
   input  wire logic          out_ready,
   output logic               take_ok,
   output logic               out_valid,
   output logic [15:0]        coil_pins,
   output logic [7:0]         enable_pins,
   output logic [3:0]         enabled_status
);

   logic        valid_ff,  valid_in;
   logic [15:0] coil_ff,   coil_in;
   logic [7:0]  enable_ff, enable_in;
   logic [3:0]  status_ff, status_in;

   always_comb begin
      for (int a = 0; a < MaxAxes; a++) begin
         coil_in[a*CoilW +: CoilW]     = lanes[a].coil;
         enable_in[a*EnableW +: EnableW] = lanes[a].enable;
         status_in[a]                  = lanes[a].powered;
      end
   end

   // the output register frees up in the same cycle its content is taken
   assign take_ok  = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         coil_ff   <= coil_in;
         enable_ff <= enable_in;
         status_ff <= status_in;
      end
   end

   assign out_valid      = valid_ff;
   assign coil_pins      = coil_ff;
   assign enable_pins    = enable_ff;
   assign enabled_status = status_ff;

endmodule
`default_nettype wire

// ===== hdl/multi_axis_stepper_phase_sequencer.sv =====
`default_nettype none
// Result: registered, valid in the cycle after its command transaction.
// Throughput: one command per cycle while the result channel is not stalled;
// the output register is refilled in the cycle its result is taken.
// Reset: synchronous; phase, coil and enable levels clear to zero, masks load
// their defaults (all axes active, four-pin, full step, no enable pins).
// ----------------------------------------------------------------------------
// multi_axis_stepper_phase_sequencer
// Phase sequencer for up to four stepper axes: one lane per axis, merged
// into a registered result.
// ----------------------------------------------------------------------------
module multi_axis_stepper_phase_sequencer
   import msps_pkg::*;
#(
   parameter int unsigned AXIS_COUNT = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   msps_req_if.sink   req_ch,
   msps_rsp_if.source rsp_ch,
   msps_csr_if.sink   csr_ch
);

   logic [MaxAxes-1:0] active_ff, four_pin_ff, half_step_ff, use_en1_ff, use_en2_ff;
   logic               load;
   logic               take_ok;
   lane_cmd_type       cmd;
   logic [StepW-1:0]   steps [MaxAxes];
   lane_out_type       lanes [MaxAxes];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '1;
         four_pin_ff  <= '1;
         half_step_ff <= '0;
         use_en1_ff   <= '0;
         use_en2_ff   <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_AXIS_ACTIVE: active_ff    <= csr_ch.data;
            CSR_FOUR_PIN:    four_pin_ff  <= csr_ch.data;
            CSR_HALF_STEP:   half_step_ff <= csr_ch.data;
            CSR_USE_EN1:     use_en1_ff   <= csr_ch.data;
            CSR_USE_EN2:     use_en2_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = take_ok;
   assign load         = req_ch.valid && take_ok;

   assign cmd.op        = op_type'(req_ch.op);
   assign cmd.level_on  = req_ch.level_on;
   assign cmd.force_req = req_ch.force_req;

   assign steps[0] = req_ch.steps_axis0;
   assign steps[1] = req_ch.steps_axis1;
   assign steps[2] = req_ch.steps_axis2;
   assign steps[3] = req_ch.steps_axis3;

   for (genvar a = 0; a < MaxAxes; a++) begin : g_axis
      if (a < AXIS_COUNT) begin : g_lane
         axis_cfg_type cfg;
         assign cfg.active    = active_ff[a];
         assign cfg.four_pin  = four_pin_ff[a];
         assign cfg.half_step = half_step_ff[a];
         assign cfg.use_en1   = use_en1_ff[a];
         assign cfg.use_en2   = use_en2_ff[a];

         msps_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .load       (load),
            .cfg        (cfg),
            .cmd        (cmd),
            .steps      (steps[a]),
            .dir_up     (req_ch.direction_up[a]),
            .target_hit (req_ch.target_axis == 2'(a)),
            .result     (lanes[a])
         );
      end else begin : g_absent
         // axes beyond the configured count read zero
         assign lanes[a] = '0;
      end
   end

   msps_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .lanes          (lanes),
      .out_ready      (rsp_ch.ready),
      .take_ok        (take_ok),
      .out_valid      (rsp_ch.valid),
      .coil_pins      (rsp_ch.coil_pins),
      .enable_pins    (rsp_ch.enable_pins),
      .enabled_status (rsp_ch.enabled_status)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_ch.valid)
      else $error("accepted command produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("command taken while result stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   a_absent_axes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.enabled_status >> AXIS_COUNT) == '0))
      else $error("status of absent axis set");

endmodule
`default_nettype wire
